@@ rtl/core/nsv_pkg.sv @@
// Types and constants shared by the numeric string validator.
package nsv_pkg;

    typedef enum logic [5:0] {
        PH_START   = 6'b000001,
        PH_INT     = 6'b000010,
        PH_FRAC    = 6'b000100,
        PH_EXP     = 6'b001000,
        PH_EXPSIGN = 6'b010000,
        PH_EXPDIG  = 6'b100000
    } t_phase;

    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_INTEGER  = 3'd1;
    localparam logic [2:0] MODE_NATURAL  = 3'd2;
    localparam logic [2:0] MODE_POSITIVE = 3'd3;
    localparam logic [2:0] MODE_REAL     = 3'd4;

    localparam logic [2:0] REG_CHECK_MODE   = 3'd0;
    localparam logic [2:0] REG_BOUND_ENABLE = 3'd1;
    localparam logic [2:0] REG_UPPER_BOUND  = 3'd2;
    localparam logic [2:0] REG_MIN_LENGTH   = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TYPE_BAD = 2'd1;
    localparam logic [1:0] STATUS_LEN_BAD  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

endpackage

@@ rtl/core/numeric_string_validator_core.sv @@
// Top level of the numeric string validator: input register, parser state and result register.
// A final word is accepted into the input register, and its status word then into the result register.
// Throughput: one word per cycle unless a stalled result holds the input; the per-character
// update is a single pass between the input register and the state and result registers.
// A stalled result blocks input only once the input register also holds a final word.
// Reset is synchronous, active low; all but the character, flag and status registers are reset.
module numeric_string_validator_core
    import nsv_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    input  logic        i_empty_string,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status
);

    localparam int CW   = LENGTH_BITS + 1;
    localparam int CMPW = (CW > 17) ? CW : 17;

    logic [2:0]         r_check_mode;
    logic               r_bound_enable;
    logic [30:0]        r_upper_bound;
    logic [16:0]        r_min_length;
    logic [16:0]        r_max_length;

    logic               r_in_valid;
    logic [7:0]         r_char;
    logic               r_last;
    logic               r_empty;

    t_phase             r_phase, n_phase;
    logic               r_type_failed, n_type_failed;
    logic               r_int_seen, n_int_seen;
    logic               r_frac_seen, n_frac_seen;
    logic [31:0]        r_acc, n_acc;
    logic [CW-1:0]      r_count, n_count;

    logic               r_out_valid;
    logic [1:0]         r_status, n_status;

    logic               is_digit, is_e, has_result, advance;
    logic [35:0]        acc_times_ten;
    logic [CMPW-1:0]    count_ext, min_ext, max_ext;
    logic               bad;

    assign o_cfg_ready = 1'b1;
    assign has_result  = r_last || r_empty;
    assign advance     = r_in_valid && (!has_result || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

    assign is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign is_e     = (r_char == CH_E_LO) || (r_char == CH_E_UP);
    assign acc_times_ten = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                         + {32'd0, r_char[3:0]};

    always_comb begin
        n_phase       = r_phase;
        n_type_failed = r_type_failed;
        n_int_seen    = r_int_seen;
        n_frac_seen   = r_frac_seen;
        n_acc         = r_acc;
        n_count       = r_count;
        if (r_empty) begin
            n_phase       = PH_START;
            n_type_failed = 1'b0;
            n_int_seen    = 1'b0;
            n_frac_seen   = 1'b0;
            n_acc         = 32'd0;
            n_count       = '0;
        end else begin
            case (r_check_mode) inside
                MODE_INTEGER: begin
                    if (!is_digit) begin
                        n_type_failed = 1'b1;
                    end
                end
                MODE_NATURAL, MODE_POSITIVE: begin
                    if (!is_digit || (r_count == '0 && r_char == CH_ZERO)) begin
                        n_type_failed = 1'b1;
                    end else if (r_check_mode == MODE_POSITIVE) begin
                        n_acc = (acc_times_ten[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                               : acc_times_ten[31:0];
                    end
                end
                MODE_REAL: begin
                    unique case (r_phase)
                        PH_START, PH_INT: begin
                            if (is_digit) begin
                                n_int_seen = 1'b1;
                                n_phase    = PH_INT;
                            end else if (r_char == CH_MINUS && r_phase == PH_START) begin
                                n_phase = PH_INT;
                            end else if (r_char == CH_POINT) begin
                                n_phase = PH_FRAC;
                            end else if (is_e) begin
                                n_phase = PH_EXP;
                            end else begin
                                n_type_failed = 1'b1;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                n_frac_seen = 1'b1;
                            end else if (is_e) begin
                                n_phase = PH_EXP;
                            end else begin
                                n_type_failed = 1'b1;
                            end
                        end
                        PH_EXP: begin
                            if (r_char == CH_PLUS || r_char == CH_MINUS) begin
                                n_phase = PH_EXPSIGN;
                            end else if (is_digit) begin
                                n_phase = PH_EXPDIG;
                            end else begin
                                n_type_failed = 1'b1;
                            end
                        end
                        PH_EXPSIGN, PH_EXPDIG: begin
                            if (is_digit) begin
                                n_phase = PH_EXPDIG;
                            end else begin
                                n_type_failed = 1'b1;
                            end
                        end
                        default: begin
                            n_type_failed = 1'b1;
                        end
                    endcase
                end
                default: begin
                end
            endcase
            if (!r_count[LENGTH_BITS]) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_comb begin
        count_ext = CMPW'(n_count);
        min_ext   = {{(CMPW-16){1'b0}}, r_min_length[15:0]};
        max_ext   = {{(CMPW-16){1'b0}}, r_max_length[15:0]};
        bad       = n_type_failed;
        if (r_check_mode == MODE_POSITIVE && r_bound_enable
                && n_acc > {1'b0, r_upper_bound}) begin
            bad = 1'b1;
        end
        if (r_check_mode == MODE_REAL) begin
            if (!n_int_seen && !n_frac_seen) begin
                bad = 1'b1;
            end
            if (n_phase == PH_EXP || n_phase == PH_EXPSIGN) begin
                bad = 1'b1;
            end
        end
        if (bad) begin
            n_status = STATUS_TYPE_BAD;
        end else if (!r_min_length[16] && count_ext < min_ext) begin
            n_status = STATUS_LEN_BAD;
        end else if (!r_max_length[16] && count_ext > max_ext) begin
            n_status = STATUS_LEN_BAD;
        end else begin
            n_status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode   <= MODE_NONE;
            r_bound_enable <= 1'b0;
            r_upper_bound  <= 31'd0;
            r_min_length   <= 17'h1FFFF;
            r_max_length   <= 17'h1FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHECK_MODE:   r_check_mode   <= i_cfg_data[2:0];
                REG_BOUND_ENABLE: r_bound_enable <= i_cfg_data[0];
                REG_UPPER_BOUND:  r_upper_bound  <= i_cfg_data;
                REG_MIN_LENGTH:   r_min_length   <= i_cfg_data[16:0];
                REG_MAX_LENGTH:   r_max_length   <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char  <= i_character;
            r_last  <= i_last;
            r_empty <= i_empty_string;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_type_failed <= 1'b0;
            r_int_seen    <= 1'b0;
            r_frac_seen   <= 1'b0;
            r_acc         <= 32'd0;
            r_count       <= '0;
        end else if (advance) begin
            if (has_result) begin
                r_phase       <= PH_START;
                r_type_failed <= 1'b0;
                r_int_seen    <= 1'b0;
                r_frac_seen   <= 1'b0;
                r_acc         <= 32'd0;
                r_count       <= '0;
            end else begin
                r_phase       <= n_phase;
                r_type_failed <= n_type_failed;
                r_int_seen    <= n_int_seen;
                r_frac_seen   <= n_frac_seen;
                r_acc         <= n_acc;
                r_count       <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_status <= n_status;
        end
    end

    a_state_cleared_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && has_result) |=> (r_count == '0 && r_phase == PH_START && !r_type_failed))
        else $error("string state not cleared after a result word");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !has_result && !r_empty && !r_count[LENGTH_BITS])
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("character count did not advance by one");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && has_result && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == STATUS_OK || r_status == STATUS_TYPE_BAD
                         || r_status == STATUS_LEN_BAD))
        else $error("result word carries an undefined status");

endmodule
